// ===== hw/rtl/bmf_pkg.sv =====
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared constants, types and helpers of the binary morphology filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

	localparam int MAX_WIDTH       = 1024;
	localparam int MAX_HALF_KERNEL = 3;
	localparam int MAX_HEIGHT      = 1024;
	localparam int WIN             = 2 * MAX_HALF_KERNEL + 1;
	localparam int LINES           = 2 * MAX_HALF_KERNEL;
	localparam int COL_W           = $clog2(MAX_WIDTH);
	localparam int DIM_W           = 11;
	localparam int HALF_W          = 2;
	localparam int OP_W            = 3;
	localparam int ROW_W           = DIM_W + 2;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 11;

	typedef logic signed [ROW_W-1:0] row_t;
	typedef logic [COL_W-1:0]        col_t;
	typedef logic [DIM_W-1:0]        dim_t;
	typedef logic [HALF_W-1:0]       half_t;

	typedef struct packed {
		row_t row;
		col_t col;
	} pos_t;

	typedef enum logic [OP_W-1:0] {
		OP_DILATE   = 3'd0,
		OP_ERODE    = 3'd1,
		OP_CLOSE    = 3'd2,
		OP_OPEN     = 3'd3,
		OP_GRADIENT = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OPERATION    = 3'd0,
		CFG_HALF_WIDTH   = 3'd1,
		CFG_HALF_HEIGHT  = 3'd2,
		CFG_IMAGE_WIDTH  = 3'd3,
		CFG_IMAGE_HEIGHT = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		EV_DILATE   = 2'd0,
		EV_ERODE    = 2'd1,
		EV_GRADIENT = 2'd2
	} ev_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD1,
		ST_PUSH1,
		ST_EVAL1,
		ST_PUSH2,
		ST_EVAL2,
		ST_OUT,
		ST_NORM
	} state_t;

	typedef struct packed {
		logic capture;
		logic push1;
		logic eval1;
		logic push2;
		logic eval2;
		logic norm;
	} cmd_t;

	typedef struct packed {
		logic proc;
		logic two_need;
		logic norm;
	} status_t;

	// step a raster position back by one stage delay (hh rows and hw pixels)
	function automatic pos_t sub_delay(pos_t p, dim_t w, half_t hw, half_t hh);
		row_t r;
		row_t c;
		row_t wx;
		pos_t res;
		r  = p.row;
		wx = {{(ROW_W-DIM_W){1'b0}}, w};
		c  = $signed({{(ROW_W-COL_W){1'b0}}, p.col}) - $signed({{(ROW_W-HALF_W){1'b0}}, hw});
		// narrow images need more than one borrow
		for (int i = 0; i < MAX_HALF_KERNEL; i++) begin
			if (c < 0) begin
				c = c + wx;
				r = r - row_t'(1);
			end
		end
		r       = r - $signed({{(ROW_W-HALF_W){1'b0}}, hh});
		res.row = r;
		res.col = c[COL_W-1:0];
		return res;
	endfunction

endpackage

// ===== hw/rtl/bmf_pixel_if.sv =====
// ----------------------------------------------------------------------------
// bmf_pixel_if
// Input channel: pixel or drain item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmf_pixel_if;
	logic valid;
	logic ready;
	logic kind;
	logic pixel_high;

	modport source (output valid, output kind, output pixel_high, input ready);
	modport sink (input valid, input kind, input pixel_high, output ready);
endinterface

// ===== hw/rtl/bmf_result_if.sv =====
// ----------------------------------------------------------------------------
// bmf_result_if
// Output channel: one result per accepted item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmf_result_if;
	logic valid;
	logic ready;
	logic out_valid;
	logic out_high;
	logic out_last;

	modport source (output valid, output out_valid, output out_high, output out_last,
		input ready);
	modport sink (input valid, input out_valid, input out_high, input out_last,
		output ready);
endinterface

// ===== hw/rtl/bmf_stage.sv =====
// ----------------------------------------------------------------------------
// bmf_stage
// One morphology stage: line store, 7x7 window and masked OR/AND evaluation.
// ----------------------------------------------------------------------------
module bmf_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             eval_en,
	input  bmf_pkg::col_t    addr,
	input  logic             pix,
	input  bmf_pkg::row_t    orow,
	input  bmf_pkg::col_t    ocol,
	input  bmf_pkg::dim_t    w,
	input  bmf_pkg::dim_t    h,
	input  bmf_pkg::half_t   hw,
	input  bmf_pkg::half_t   hh,
	input  bmf_pkg::ev_kind_t kind,
	output logic             res
);

	logic [bmf_pkg::LINES-1:0] mem [bmf_pkg::MAX_WIDTH];
	logic [bmf_pkg::LINES-1:0] rd_q;
	logic [bmf_pkg::WIN-1:0]   win_q [bmf_pkg::WIN];
	logic [bmf_pkg::WIN-1:0]   vec;
	logic [bmf_pkg::WIN-1:0]   rv;
	logic [bmf_pkg::WIN-1:0]   cv;
	bmf_pkg::row_t             rr [bmf_pkg::WIN];
	bmf_pkg::row_t             cc [bmf_pkg::WIN];
	logic                      any_d;
	logic                      all_d;
	logic                      res_d;
	logic                      res_q;

	always_ff @(posedge clk) begin
		rd_q <= mem[addr];
		if (push) begin
			mem[addr] <= {rd_q[bmf_pkg::LINES-2:0], pix};
		end
	end

	assign vec = {rd_q, pix};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < bmf_pkg::WIN; r++) begin
				win_q[r] <= '0;
			end
		end else if (push) begin
			for (int r = 0; r < bmf_pkg::WIN; r++) begin
				win_q[r] <= {vec[r], win_q[r][bmf_pkg::WIN-1:1]};
			end
		end
	end

	// neighbours outside the kernel or outside the image drop out
	always_comb begin
		for (int r = 0; r < bmf_pkg::WIN; r++) begin
			rr[r] = orow + $signed({{(bmf_pkg::ROW_W-bmf_pkg::HALF_W){1'b0}}, hh})
				- bmf_pkg::row_t'(r);
			rv[r] = (r <= 2 * int'(hh)) && (rr[r] >= 0)
				&& (rr[r] < $signed({2'b00, h}));
		end
		for (int c = 0; c < bmf_pkg::WIN; c++) begin
			cc[c] = $signed({{(bmf_pkg::ROW_W-bmf_pkg::COL_W){1'b0}}, ocol})
				+ bmf_pkg::row_t'(c) - bmf_pkg::row_t'(bmf_pkg::WIN - 1)
				+ $signed({{(bmf_pkg::ROW_W-bmf_pkg::HALF_W){1'b0}}, hw});
			cv[c] = (c >= bmf_pkg::WIN - 1 - 2 * int'(hw)) && (cc[c] >= 0)
				&& (cc[c] < $signed({2'b00, w}));
		end
		any_d = 1'b0;
		all_d = 1'b1;
		for (int r = 0; r < bmf_pkg::WIN; r++) begin
			for (int c = 0; c < bmf_pkg::WIN; c++) begin
				if (rv[r] && cv[c]) begin
					any_d = any_d | win_q[r][c];
					all_d = all_d & win_q[r][c];
				end
			end
		end
		case (kind)
			bmf_pkg::EV_ERODE:    res_d = all_d;
			bmf_pkg::EV_GRADIENT: res_d = any_d & ~all_d;
			default:              res_d = any_d;
		endcase
	end

	always_ff @(posedge clk) begin
		if (eval_en) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

endmodule

// ===== hw/rtl/bmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmf_ctrl
// Sequencer: capture, line read, push and evaluate per stage, then result.
// ----------------------------------------------------------------------------
module bmf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_ready,
	input  bmf_pkg::status_t  status,
	output bmf_pkg::cmd_t     cmd,
	output logic              in_ready,
	output logic              out_valid
);

	bmf_pkg::state_t state_q;
	bmf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bmf_pkg::ST_IDLE: begin
				if (in_valid) begin
					// column past the row end after a width change: rewrap first
					if (status.norm) begin
						state_d = bmf_pkg::ST_NORM;
					end else begin
						// ignored drain items skip the stages
						state_d = status.proc ? bmf_pkg::ST_RD1 : bmf_pkg::ST_OUT;
					end
				end
			end
			bmf_pkg::ST_NORM: begin
				state_d = status.norm ? bmf_pkg::ST_NORM : bmf_pkg::ST_IDLE;
			end
			bmf_pkg::ST_RD1:   state_d = bmf_pkg::ST_PUSH1;
			bmf_pkg::ST_PUSH1: state_d = bmf_pkg::ST_EVAL1;
			bmf_pkg::ST_EVAL1: begin
				state_d = status.two_need ? bmf_pkg::ST_PUSH2 : bmf_pkg::ST_OUT;
			end
			bmf_pkg::ST_PUSH2: state_d = bmf_pkg::ST_EVAL2;
			bmf_pkg::ST_EVAL2: state_d = bmf_pkg::ST_OUT;
			bmf_pkg::ST_OUT: begin
				if (out_ready) begin
					state_d = bmf_pkg::ST_IDLE;
				end
			end
			default: state_d = bmf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			bmf_pkg::ST_IDLE: begin
				in_ready    = !status.norm;
				cmd.capture = in_valid && !status.norm;
			end
			bmf_pkg::ST_NORM:  cmd.norm  = 1'b1;
			bmf_pkg::ST_PUSH1: cmd.push1 = 1'b1;
			bmf_pkg::ST_EVAL1: cmd.eval1 = 1'b1;
			bmf_pkg::ST_PUSH2: cmd.push2 = 1'b1;
			bmf_pkg::ST_EVAL2: cmd.eval2 = 1'b1;
			bmf_pkg::ST_OUT:   out_valid = 1'b1;
			default: begin
			end
		endcase
	end

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output handshakes open together");

	a_capture_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == bmf_pkg::ST_RD1 || state_q == bmf_pkg::ST_OUT))
		else $error("bad state after capture");

	a_push2_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push2 |-> $past(cmd.eval1) && status.two_need)
		else $error("second stage pushed out of order");

	a_eval2_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval2 |-> $past(cmd.push2))
		else $error("second stage evaluated without push");

endmodule

// ===== hw/rtl/bmf_dp.sv =====
// ----------------------------------------------------------------------------
// bmf_dp
// Datapath: registers, raster counters, position arithmetic, two stages.
// ----------------------------------------------------------------------------
module bmf_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bmf_pkg::cmd_t                     cmd,
	output bmf_pkg::status_t                  status,
	input  logic                              kind,
	input  logic                              pixel_high,
	input  logic                              cfg_we,
	input  logic [bmf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bmf_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              out_valid,
	output logic                              out_high,
	output logic                              out_last
);

	logic [bmf_pkg::OP_W-1:0] op_q;
	bmf_pkg::half_t           hw_q;
	bmf_pkg::half_t           hh_q;
	bmf_pkg::dim_t            iw_q;
	bmf_pkg::dim_t            ih_q;

	bmf_pkg::dim_t     weff;
	bmf_pkg::dim_t     heff;
	logic              two;
	bmf_pkg::ev_kind_t k1;
	bmf_pkg::ev_kind_t k2;

	bmf_pkg::dim_t row_q;
	bmf_pkg::col_t col_q;

	logic          norm_d;
	logic          over;
	bmf_pkg::pos_t pos_d;
	bmf_pkg::pos_t m_d;
	bmf_pkg::pos_t q_d;
	logic          proc_d;

	bmf_pkg::pos_t m_q;
	bmf_pkg::pos_t q_q;
	bmf_pkg::col_t col1_q;
	logic          pix_q;
	logic          two_need_q;
	logic          ov_q;
	logic          last_q;
	logic          two_q;

	logic res1;
	logic res2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= bmf_pkg::OP_DILATE;
			hw_q <= bmf_pkg::half_t'(1);
			hh_q <= bmf_pkg::half_t'(1);
			iw_q <= bmf_pkg::dim_t'(640);
			ih_q <= bmf_pkg::dim_t'(480);
		end else if (cfg_we) begin
			unique case (bmf_pkg::cfg_idx_t'(cfg_index))
				bmf_pkg::CFG_OPERATION:    op_q <= cfg_data[bmf_pkg::OP_W-1:0];
				bmf_pkg::CFG_HALF_WIDTH:   hw_q <= cfg_data[bmf_pkg::HALF_W-1:0];
				bmf_pkg::CFG_HALF_HEIGHT:  hh_q <= cfg_data[bmf_pkg::HALF_W-1:0];
				bmf_pkg::CFG_IMAGE_WIDTH:  iw_q <= cfg_data[bmf_pkg::DIM_W-1:0];
				bmf_pkg::CFG_IMAGE_HEIGHT: ih_q <= cfg_data[bmf_pkg::DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		weff = (iw_q == '0) ? bmf_pkg::dim_t'(1)
			: (iw_q > bmf_pkg::dim_t'(bmf_pkg::MAX_WIDTH)) ? bmf_pkg::dim_t'(bmf_pkg::MAX_WIDTH)
			: iw_q;
		heff = (ih_q == '0) ? bmf_pkg::dim_t'(1)
			: (ih_q > bmf_pkg::dim_t'(bmf_pkg::MAX_HEIGHT)) ? bmf_pkg::dim_t'(bmf_pkg::MAX_HEIGHT)
			: ih_q;
		two = 1'b0;
		k1  = bmf_pkg::EV_DILATE;
		k2  = bmf_pkg::EV_DILATE;
		case (bmf_pkg::op_t'(op_q))
			bmf_pkg::OP_ERODE: k1 = bmf_pkg::EV_ERODE;
			bmf_pkg::OP_CLOSE: begin
				two = 1'b1;
				k2  = bmf_pkg::EV_ERODE;
			end
			bmf_pkg::OP_OPEN: begin
				two = 1'b1;
				k1  = bmf_pkg::EV_ERODE;
			end
			bmf_pkg::OP_GRADIENT: k1 = bmf_pkg::EV_GRADIENT;
			default: begin
			end
		endcase
	end

	// a narrower image can leave the column past the row end
	assign norm_d = ({1'b0, col_q} >= weff);

	// position of this item, then the positions leaving stage one and the block
	always_comb begin
		over = (row_q >= heff);
		if (!kind && over) begin
			pos_d = '0;
		end else begin
			pos_d.row = {2'b00, row_q};
			pos_d.col = col_q;
		end
		m_d = bmf_pkg::sub_delay(pos_d, weff, hw_q, hh_q);
		q_d = two ? bmf_pkg::sub_delay(m_d, weff, hw_q, hh_q) : m_d;
		// drain only counts between the last pixel and the end of the flush
		proc_d = !kind || (over && ((q_d.row < 0) || (q_d.row < $signed({2'b00, heff}))));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.norm && norm_d) begin
			// one row per cycle; a saturated row is far past any frame end
			col_q <= col_q - weff[bmf_pkg::COL_W-1:0];
			row_q <= (row_q == '1) ? row_q : row_q + bmf_pkg::dim_t'(1);
		end else if (cmd.capture && proc_d) begin
			if ({1'b0, pos_d.col} == weff - bmf_pkg::dim_t'(1)) begin
				row_q <= pos_d.row[bmf_pkg::DIM_W-1:0] + bmf_pkg::dim_t'(1);
				col_q <= '0;
			end else begin
				row_q <= pos_d.row[bmf_pkg::DIM_W-1:0];
				col_q <= pos_d.col + bmf_pkg::col_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			m_q        <= m_d;
			q_q        <= q_d;
			col1_q     <= pos_d.col;
			// drain items push a low pixel
			pix_q      <= pixel_high & ~kind;
			two_q      <= two;
			two_need_q <= two && (m_d.row >= 0);
			ov_q       <= proc_d && (q_d.row >= 0);
			last_q     <= (q_d.row == $signed({2'b00, heff - bmf_pkg::dim_t'(1)}))
				&& ({1'b0, q_d.col} == weff - bmf_pkg::dim_t'(1));
		end
	end

	assign status.proc     = proc_d;
	assign status.two_need = two_need_q;
	assign status.norm     = norm_d;

	bmf_stage u_stage1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd.push1),
		.eval_en (cmd.eval1),
		.addr    (col1_q),
		.pix     (pix_q),
		.orow    (m_q.row),
		.ocol    (m_q.col),
		.w       (weff),
		.h       (heff),
		.hw      (hw_q),
		.hh      (hh_q),
		.kind    (k1),
		.res     (res1)
	);

	bmf_stage u_stage2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd.push2),
		.eval_en (cmd.eval2),
		.addr    (m_q.col),
		.pix     (res1),
		.orow    (q_q.row),
		.ocol    (q_q.col),
		.w       (weff),
		.h       (heff),
		.hw      (hw_q),
		.hh      (hh_q),
		.kind    (k2),
		.res     (res2)
	);

	assign out_valid = ov_q;
	assign out_high  = ov_q & (two_q ? res2 : res1);
	assign out_last  = ov_q & last_q;

endmodule

// ===== hw/rtl/binary_morphology_filter_unit.sv =====
// ----------------------------------------------------------------------------
// binary_morphology_filter_unit
// Binary dilate/erode/close/open/gradient with a rectangular kernel.
// ----------------------------------------------------------------------------
// Usage: pixels enter in raster order on in_stream (kind 0 with pixel_high,
// kind 1 for drain items that flush the last rows after a frame). Every
// accepted item yields exactly one transaction on out_stream; out_valid in
// that transaction says whether it carries an output pixel, out_last marks
// the final pixel of the frame.
// Sequence: after an item is accepted, stage one reads its line store, then
// pushes the window and evaluates; for close and open, once the second stage
// is fed, stage two then pushes and evaluates before the result is offered.
// An ignored drain skips the stages and goes straight to the result.
// After the image width is narrowed, the first item waits while the stored
// column is wrapped back, one row per cycle.
// The block takes one item at a time: while a result waits on a stalled
// receiver, in_stream.ready stays low and nothing is lost.
// Reset restores the default registers and the raster position; the line
// stores are not cleared, their stale entries only reach ignored neighbours.
// ----------------------------------------------------------------------------
module binary_morphology_filter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	bmf_pixel_if.sink                      in_stream,
	bmf_result_if.source                   out_stream,
	input  logic                           cfg_we,
	input  logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmf_pkg::CFG_DATA_W-1:0] cfg_data
);

	bmf_pkg::cmd_t    cmd;
	bmf_pkg::status_t status;

	bmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_stream.valid),
		.out_ready (out_stream.ready),
		.status    (status),
		.cmd       (cmd),
		.in_ready  (in_stream.ready),
		.out_valid (out_stream.valid)
	);

	bmf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.kind       (in_stream.kind),
		.pixel_high (in_stream.pixel_high),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_stream.out_valid),
		.out_high   (out_stream.out_high),
		.out_last   (out_stream.out_last)
	);

endmodule

// ===== test/binary_morphology_filter_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_morphology_filter_unit_tb
// Drives raster frames of binary pixels and drain items through the filter
// under several kernel, size and operation settings. Every result transaction
// is compared with a behavioral model of the two-stage window filter.
// ----------------------------------------------------------------------------
module binary_morphology_filter_unit_tb;

	localparam int CLK_PERIOD = 12;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS = 450;
	localparam int WIN = bmf_pkg::WIN;
	localparam int LINES = bmf_pkg::LINES;
	localparam int MAX_WIDTH = bmf_pkg::MAX_WIDTH;
	localparam int MAX_HEIGHT = bmf_pkg::MAX_HEIGHT;

	typedef struct packed {
		logic ov;
		logic oh;
		logic ol;
	} pix_result_t;

	typedef struct {
		logic kind;
		logic pix;
		logic typed;
		pix_result_t res;
	} stim_row_t;

	typedef struct {
		logic [bmf_pkg::OP_W-1:0] op;
		int hw;
		int hh;
		int w;
		int h;
	} setting_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [bmf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bmf_pkg::CFG_DATA_W-1:0] cfg_data;

	bmf_pixel_if in_s ();
	bmf_result_if out_r ();

	binary_morphology_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_stream (in_s),
		.out_stream(out_r),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// filter model state
	bit line_mem [2][LINES*MAX_WIDTH];
	bit win_mem [2][WIN][WIN];
	int in_col, in_row;
	logic [bmf_pkg::OP_W-1:0] m_op;
	int m_hw, m_hh, m_w, m_h;

	pix_result_t expected_pixels[$];
	int fails = 0;
	int mode = 0;
	bit hold_req = 0;
	int cycles = 0;

	function automatic void win_push(int s, bit p, int col);
		bit v [WIN];
		v[0] = p;
		for (int k = 0; k < LINES; k++)
			v[k+1] = line_mem[s][k*MAX_WIDTH + col];
		for (int k = LINES - 1; k >= 1; k--)
			line_mem[s][k*MAX_WIDTH + col] = line_mem[s][(k-1)*MAX_WIDTH + col];
		line_mem[s][col] = p;
		for (int r = 0; r < WIN; r++) begin
			for (int c = 0; c < WIN - 1; c++)
				win_mem[s][r][c] = win_mem[s][r][c+1];
			win_mem[s][r][WIN-1] = v[r];
		end
	endfunction

	function automatic bit win_eval(int s, bmf_pkg::ev_kind_t kd, int orow, int ocol,
		int w, int h, int hw, int hh);
		bit any_hi, all_hi;
		int rr, cc;
		any_hi = 0;
		all_hi = 1;
		for (int dy = -hh; dy <= hh; dy++)
			for (int dx = -hw; dx <= hw; dx++) begin
				rr = orow + dy;
				cc = ocol + dx;
				if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
					any_hi |= win_mem[s][hh-dy][WIN-1-hw+dx];
					all_hi &= win_mem[s][hh-dy][WIN-1-hw+dx];
				end
			end
		if (kd == bmf_pkg::EV_DILATE) return any_hi;
		if (kd == bmf_pkg::EV_ERODE) return all_hi;
		return any_hi & ~all_hi;
	endfunction

	// effective sizes after clamping
	function automatic int eff_w();
		return (m_w < 1) ? 1 : (m_w > MAX_WIDTH) ? MAX_WIDTH : m_w;
	endfunction
	function automatic int eff_h();
		return (m_h < 1) ? 1 : (m_h > MAX_HEIGHT) ? MAX_HEIGHT : m_h;
	endfunction
	function automatic int stage_delay();
		return m_hh * eff_w() + m_hw;
	endfunction
	function automatic bit two_stage();
		return m_op == bmf_pkg::OP_CLOSE || m_op == bmf_pkg::OP_OPEN;
	endfunction
	function automatic int raster_pos();
		return in_row * eff_w() + in_col;
	endfunction

	function automatic pix_result_t filter_step(bit kind, bit p);
		pix_result_t res;
		int w, h, frame, d, dtot, n, m, q;
		bit two, v;
		bmf_pkg::ev_kind_t k1, k2;
		bmf_pkg::op_t op;
		w = eff_w();
		h = eff_h();
		op = (m_op > bmf_pkg::OP_GRADIENT) ? bmf_pkg::OP_DILATE : bmf_pkg::op_t'(m_op);
		two = (op == bmf_pkg::OP_CLOSE || op == bmf_pkg::OP_OPEN);
		k1 = (op == bmf_pkg::OP_ERODE || op == bmf_pkg::OP_OPEN) ? bmf_pkg::EV_ERODE :
			(op == bmf_pkg::OP_GRADIENT) ? bmf_pkg::EV_GRADIENT : bmf_pkg::EV_DILATE;
		k2 = (op == bmf_pkg::OP_CLOSE) ? bmf_pkg::EV_ERODE : bmf_pkg::EV_DILATE;
		frame = w * h;
		d = m_hh * w + m_hw;
		dtot = two ? 2 * d : d;
		n = in_row * w + in_col;
		q = -1;
		v = 0;
		res = '0;
		if (kind) begin
			if (n < frame || n >= frame + dtot) return res;
			p = 0;
		end else if (n >= frame) begin
			n = 0;
		end
		win_push(0, p, n % w);
		m = n - d;
		if (m >= 0) begin
			v = win_eval(0, k1, m / w, m % w, w, h, m_hw, m_hh);
			if (two) begin
				win_push(1, v, m % w);
				q = m - d;
				if (q >= 0) v = win_eval(1, k2, q / w, q % w, w, h, m_hw, m_hh);
			end else begin
				q = m;
			end
		end
		if (q >= 0 && q < frame) begin
			res.ov = 1;
			res.oh = v;
			res.ol = (q == frame - 1);
		end
		n++;
		in_row = n / w;
		in_col = n % w;
		return res;
	endfunction

	initial begin
		clk = 0;
		forever #(CLK_PERIOD/2) clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int idle_pct(bit sender);
		case (mode)
			0: return sender ? 32 : 74;
			1: return sender ? 74 : 32;
			default: return 0;
		endcase
	endfunction

	// receiver side: random stalls, one long hold-off, checks each transaction
	initial begin
		pix_result_t got, exp_r;
		out_r.ready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				out_r.ready <= 0;
				repeat (300) @(posedge clk);
			end
			out_r.ready <= ($urandom_range(99) >= idle_pct(0));
			@(posedge clk);
			if (out_r.valid && out_r.ready) begin
				got = '{out_r.out_valid, out_r.out_high, out_r.out_last};
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected transaction %b", $time, got);
					fails++;
				end else begin
					exp_r = expected_pixels.pop_front();
					if (got.ov !== exp_r.ov)
						$display("%0t: out_valid expected %b actual %b", $time, exp_r.ov, got.ov);
					if (got.oh !== exp_r.oh)
						$display("%0t: out_high expected %b actual %b", $time, exp_r.oh, got.oh);
					if (got.ol !== exp_r.ol)
						$display("%0t: out_last expected %b actual %b", $time, exp_r.ol, got.ol);
					if (got !== exp_r) fails++;
				end
			end
		end
	end

	task automatic send_pixel(bit kind, bit p, bit typed, pix_result_t typed_res);
		pix_result_t pred;
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct(1) && gap < 20) gap++;
		if (gap > 0) begin
			in_s.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_s.valid <= 1;
		in_s.kind <= kind;
		in_s.pixel_high <= p;
		do @(posedge clk); while (!in_s.ready);
		pred = filter_step(kind, p);
		expected_pixels.push_back(typed ? typed_res : pred);
	endtask

	task automatic wait_drained();
		in_s.valid <= 0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(bmf_pkg::cfg_idx_t idx, int val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= bmf_pkg::CFG_DATA_W'(val);
		@(posedge clk);
		case (idx)
			bmf_pkg::CFG_OPERATION: m_op = val[bmf_pkg::OP_W-1:0];
			bmf_pkg::CFG_HALF_WIDTH: m_hw = val & 3;
			bmf_pkg::CFG_HALF_HEIGHT: m_hh = val & 3;
			bmf_pkg::CFG_IMAGE_WIDTH: m_w = val & 11'h7FF;
			default: m_h = val & 11'h7FF;
		endcase
	endtask

	task automatic apply_setting(setting_t st);
		wait_drained();
		write_reg(bmf_pkg::CFG_OPERATION, st.op);
		write_reg(bmf_pkg::CFG_HALF_WIDTH, st.hw);
		write_reg(bmf_pkg::CFG_HALF_HEIGHT, st.hh);
		write_reg(bmf_pkg::CFG_IMAGE_WIDTH, st.w);
		write_reg(bmf_pkg::CFG_IMAGE_HEIGHT, st.h);
		cfg_we <= 0;
	endtask

	// one frame plus flush; returns pixel count
	task automatic run_frame(output int sent);
		int dens, frame, dtot;
		sent = 0;
		dens = $urandom_range(2) == 0 ? 15 : ($urandom_range(1) ? 50 : 85);
		frame = eff_w() * eff_h();
		dtot = two_stage() ? 2 * stage_delay() : stage_delay();
		// a pixel at or past the frame end starts a new frame
		if (raster_pos() >= frame) begin
			send_pixel(0, $urandom_range(99) < dens, 0, '0);
			sent++;
		end
		while (raster_pos() < frame) begin
			if ($urandom_range(99) < 3) send_pixel(1, $urandom_range(1), 0, '0);
			send_pixel(0, $urandom_range(99) < dens, 0, '0);
			sent++;
		end
		while (raster_pos() < frame + dtot) send_pixel(1, $urandom_range(1), 0, '0);
		repeat ($urandom_range(2)) send_pixel(1, $urandom_range(1), 0, '0);
	endtask

	initial begin
		stim_row_t dir_rows [$];
		setting_t fixed_set [$];
		setting_t st;
		int sent, total;
		bit hold_done;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_s.valid = 0;
		in_s.kind = 0;
		in_s.pixel_high = 0;
		m_op = bmf_pkg::OP_DILATE;
		m_hw = 1;
		m_hh = 1;
		m_w = 640;
		m_h = 480;
		in_col = 0;
		in_row = 0;
		hold_done = 0;
		@(posedge arst_n);
		@(posedge clk);

		// reset settings: 640 wide, so no output before item 641
		dir_rows.push_back('{1, 1, 1, '0});
		for (int i = 0; i < 18; i++)
			dir_rows.push_back('{0, (i % 3) != 0, 1, '0});
		dir_rows.push_back('{1, 0, 1, '0});
		dir_rows.push_back('{0, 1, 1, '0});
		foreach (dir_rows[i])
			send_pixel(dir_rows[i].kind, dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].res);

		// the first width cut lands mid-frame with the column past the new row end
		fixed_set.push_back('{bmf_pkg::OP_OPEN, 3, 3, 12, 7});
		fixed_set.push_back('{bmf_pkg::OP_DILATE, 0, 0, 1, 1});
		fixed_set.push_back('{bmf_pkg::OP_ERODE, 3, 3, 0, 0});
		fixed_set.push_back('{3'd7, 1, 2, 1, 20});
		fixed_set.push_back('{bmf_pkg::OP_GRADIENT, 3, 0, 5, 4});
		fixed_set.push_back('{bmf_pkg::OP_CLOSE, 2, 3, 4, 6});
		fixed_set.push_back('{3'd5, 0, 3, 3, 9});
		foreach (fixed_set[i]) begin
			apply_setting(fixed_set[i]);
			run_frame(sent);
		end

		total = 0;
		while (total < RANDOM_ITEMS) begin
			mode = (total < RANDOM_ITEMS / 3) ? 0 : (total < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
			if ($urandom_range(1)) begin
				st.op = $urandom_range(7);
				st.hw = $urandom_range(3);
				st.hh = $urandom_range(3);
				st.w = $urandom_range(24, 1);
				st.h = $urandom_range(10, 1);
				apply_setting(st);
			end
			if (total > 0 && !hold_done) begin
				hold_req = 1;
				hold_done = 1;
			end
			run_frame(sent);
			total += sent;
		end

		in_s.valid <= 0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/bmf_pkg.sv
hw/rtl/bmf_pixel_if.sv
hw/rtl/bmf_result_if.sv
hw/rtl/bmf_stage.sv
hw/rtl/bmf_ctrl.sv
hw/rtl/bmf_dp.sv
hw/rtl/binary_morphology_filter_unit.sv
test/binary_morphology_filter_unit_tb.sv
